### hdl/nbrs_pkg.sv
// Shared types, constants and helpers for the radar sweep beacon search.
package nbrs_pkg;

  localparam int BEACONS    = 256;
  localparam int IDX_W      = 8;
  localparam int ANGLE_BITS = 16;
  localparam int CNT_W      = 9;
  localparam int ITER_W     = 5;
  localparam logic signed [39:0] CORDIC_K = 40'sd652032874;

  typedef enum logic [2:0] {
    REG_OFF_X   = 3'd0,
    REG_OFF_Y   = 3'd1,
    REG_SWEEP   = 3'd2,
    REG_MAXRNG  = 3'd3,
    REG_BCOUNT  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CORDIC_ROT = 2'd0,
    CORDIC_VEC = 2'd1
  } cordic_mode_t;

  // Arctangent table in 32-bit binary angle units.
  function automatic logic [31:0] atan_lut(input logic [ITER_W-1:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_POSE1,  ST_POSE1_W, ST_POSE1_M,
    ST_POSE2,  ST_POSE2_W, ST_POSE2_M,
    ST_AIM_M,
    ST_AIM1,   ST_AIM1_W,
    ST_AIM2,   ST_AIM2_W,
    ST_RD,     ST_DIFF,    ST_MUL,     ST_SQRT,   ST_CMP,
    ST_ATAN,   ST_ATAN_W,
    ST_FIN,    ST_FIN_W,   ST_FIN_M,   ST_FIN_S,
    ST_OUT
  } state_t;

endpackage

### hdl/nbrs_ram.sv
// Generic single-port write, single-port read RAM with registered read data.
module nbrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/nbrs_cordic.sv
// Iterative CORDIC: rotation mode gives cos/sin in Q1.30, vectoring gives atan2.
module nbrs_cordic
  import nbrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  cordic_mode_t        mode,
  input  logic [31:0]         angle,
  input  logic signed [39:0]  vec_x,
  input  logic signed [39:0]  vec_y,
  output logic                done,
  output logic signed [39:0]  cos_o,
  output logic signed [39:0]  sin_o,
  output logic [31:0]         ang_o
);

  logic signed [39:0] x_r, y_r, x_nxt, y_nxt;
  logic [31:0]        z_r, z_nxt;
  logic [ITER_W-1:0]  k_r, k_nxt;
  logic               busy_r, busy_nxt, flip_r, flip_nxt, mode_r, mode_nxt;
  logic               done_r, done_nxt;
  logic signed [39:0] sx, sy;
  logic [31:0]        a_adj;

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; k_nxt = k_r;
    busy_nxt = busy_r; flip_nxt = flip_r; mode_nxt = mode_r; done_nxt = 1'b0;
    sx = x_r >>> k_r;
    sy = y_r >>> k_r;
    a_adj = angle;
    if (start) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
      mode_nxt = (mode == CORDIC_VEC);
      if (mode == CORDIC_VEC) begin
        flip_nxt = 1'b0;
        if (vec_x < 0) begin
          x_nxt = -vec_x; y_nxt = -vec_y; z_nxt = 32'h8000_0000;
        end else begin
          x_nxt = vec_x; y_nxt = vec_y; z_nxt = '0;
        end
        // zero vector gives angle zero
        if (vec_x == 0 && vec_y == 0) begin
          busy_nxt = 1'b0; done_nxt = 1'b1; z_nxt = '0;
        end
      end else begin
        flip_nxt = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
        if (flip_nxt) begin
          a_adj = angle + 32'h8000_0000;
        end
        x_nxt = CORDIC_K; y_nxt = '0; z_nxt = a_adj;
      end
    end else if (busy_r) begin
      if (mode_r) begin
        if (y_r > 0) begin
          x_nxt = x_r + sy; y_nxt = y_r - sx; z_nxt = z_r + atan_lut(k_r);
        end else begin
          x_nxt = x_r - sy; y_nxt = y_r + sx; z_nxt = z_r - atan_lut(k_r);
        end
      end else begin
        if (!z_r[31]) begin
          x_nxt = x_r - sy; y_nxt = y_r + sx; z_nxt = z_r - atan_lut(k_r);
        end else begin
          x_nxt = x_r + sy; y_nxt = y_r - sx; z_nxt = z_r + atan_lut(k_r);
        end
      end
      k_nxt = k_r + 1'b1;
      if (k_r == ITER_W'(ANGLE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (!mode_r && flip_r) begin
          x_nxt = -x_nxt; y_nxt = -y_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; k_r <= k_nxt;
    flip_r <= flip_nxt; mode_r <= mode_nxt;
  end

  assign done  = done_r;
  assign cos_o = x_r;
  assign sin_o = y_r;
  assign ang_o = z_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("cordic done while busy");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("cordic restarted while busy");
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> k_r < ITER_W'(ANGLE_BITS)) else $error("cordic iteration overrun");

endmodule

### hdl/nbrs_isqrt.sv
// Bit-serial integer square root of a 64-bit value, two radicand bits per cycle.
module nbrs_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] n_r, n_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [63:0] trial;

  always_comb begin
    n_nxt = n_r; res_nxt = res_r; bit_nxt = bit_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = res_r + bit_r;
    if (start) begin
      n_nxt = rad; res_nxt = '0; bit_nxt = 64'h4000_0000_0000_0000;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (n_r >= trial) begin
        n_nxt = n_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    n_r <= n_nxt; res_r <= res_nxt; bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

### hdl/nearest_beacon_in_radar_sweep.sv
// Top level: beacon table load and nearest-beacon search across a radar sweep.
//
// Usage:
//   in_*  : item stream. tuser = func (0 load a beacon, 1 observe two poses).
//           A load writes beacon_x/beacon_y into slot beacon_slot and gives
//           no result. An observe gives exactly one result item.
//   out_* : result stream; found, range, bearing, beacon_index, world_x,
//           world_y, time_stamp.
//   cfg_* : register writes (offsets, sweep rate, max range, beacon count),
//           made by the user only while no observe is in flight (not checked).
// Sequence:
//   An observe runs CORDIC rotations for the two poses and two aim angles,
//   then for each searched beacon a read, difference, products, a bit-serial
//   square root and a compare (no square root when the beacon is out of
//   reach); if a beacon was found, it then finds bearing and world position.
//   The CORDIC and square-root units are shared and the table has a single
//   read, so the steps run one after another and no item is taken meanwhile.
// Reset: control and registers return to their reset values; the beacon
//   table content is undefined until loaded.
// Stall: a held result stays in the output register while the next items are
//   taken; a finished observe waits in its last state until the register frees.
module nearest_beacon_in_radar_sweep
  import nbrs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata from bit 0: beacon_slot[8], beacon_x[32], beacon_y[32], start_x[32],
  // start_y[32], start_heading[16], start_time[32], end_x[32], end_y[32],
  // end_heading[16], end_time[32]
  input  logic [295:0] in_tdata,
  // tuser: func
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata from bit 0: found, range[31], bearing[16], beacon_index[8],
  // world_x[32], world_y[32], time_stamp[32]
  output logic [151:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  // ---------------- configuration ----------------
  logic signed [31:0] off_x_r, off_y_r;
  logic [31:0]        sweep_r;
  logic [30:0]        maxr_r;
  logic [CNT_W-1:0]   bcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0; off_y_r <= '0; sweep_r <= '0;
      maxr_r <= 31'h7FFF_FFFF; bcnt_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFF_X:  off_x_r <= cfg_wdata;
        REG_OFF_Y:  off_y_r <= cfg_wdata;
        REG_SWEEP:  sweep_r <= cfg_wdata;
        REG_MAXRNG: maxr_r  <= cfg_wdata[30:0];
        REG_BCOUNT: bcnt_r  <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input fields ----------------
  logic [IDX_W-1:0]   f_slot;
  logic [31:0]        f_bx, f_by;
  assign f_slot = in_tdata[7:0];
  assign f_bx   = in_tdata[39:8];
  assign f_by   = in_tdata[71:40];

  // observe item held while searching
  logic signed [31:0] sx_r, sy_r, ex_r, ey_r;
  logic [15:0]        sh_r, eh_r;
  logic [31:0]        st_r, et_r;

  // ---------------- state ----------------
  state_t st_cur_r, st_nxt;
  logic   accept_in, is_load;
  logic   out_valid_r, out_free;
  assign is_load   = !in_tuser;
  assign in_tready = (st_cur_r == ST_IDLE);
  assign accept_in = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // ---------------- beacon table ----------------
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      bx_rd, by_rd;
  logic [CNT_W-1:0] idx_r, idx_nxt, lim;
  logic             tbl_we;
  assign tbl_we = accept_in && is_load;

  nbrs_ram #(.WIDTH(32), .DEPTH(BEACONS)) u_xtab (
    .clk, .we(tbl_we), .waddr(f_slot), .wdata(f_bx), .raddr(rd_addr), .rdata(bx_rd)
  );
  nbrs_ram #(.WIDTH(32), .DEPTH(BEACONS)) u_ytab (
    .clk, .we(tbl_we), .waddr(f_slot), .wdata(f_by), .raddr(rd_addr), .rdata(by_rd)
  );

  // ---------------- shared units ----------------
  logic               cs_start, cs_done, sq_start, sq_done;
  cordic_mode_t       cs_mode;
  logic [31:0]        cs_angle, cs_ang;
  logic signed [39:0] cs_vx, cs_vy, cs_cos, cs_sin;
  logic [63:0]        sq_rad;
  logic [31:0]        sq_root;

  nbrs_cordic u_cordic (
    .clk, .rst_n, .start(cs_start), .mode(cs_mode), .angle(cs_angle),
    .vec_x(cs_vx), .vec_y(cs_vy), .done(cs_done), .cos_o(cs_cos),
    .sin_o(cs_sin), .ang_o(cs_ang)
  );
  nbrs_isqrt u_isqrt (
    .clk, .rst_n, .start(sq_start), .rad(sq_rad), .done(sq_done), .root(sq_root)
  );

  // ---------------- datapath registers ----------------
  logic signed [63:0] pa_r, pb_r, pc_r, pd_r; // products
  logic signed [33:0] rx1_r, ry1_r, rx2_r, ry2_r;
  logic [63:0]        tp1_r, tp2_r;
  logic signed [25:0] c1_r, s1_r, c2_r, s2_r; // Q1.16
  logic signed [34:0] dx_r, dy_r, ex2_r, ey2_r;
  logic               skip_r;
  logic [31:0]        best_r;
  logic [IDX_W-1:0]   bidx_r;
  logic               found_r;
  logic signed [34:0] bdx_r, bdy_r;
  logic [15:0]        brg_r;

  logic [151:0] out_data_r;

  logic signed [63:0] d1, d2, sqx, sqy;
  logic               cmp_hit, skip_now;
  logic signed [31:0] cos32, sin32;

  assign lim = (bcnt_r > CNT_W'(BEACONS)) ? CNT_W'(BEACONS) : bcnt_r;
  assign rd_addr = idx_r[IDX_W-1:0];
  // CORDIC magnitudes stay below 2^31
  assign cos32 = cs_cos[31:0];
  assign sin32 = cs_sin[31:0];

  // next state
  always_comb begin
    st_nxt = st_cur_r;
    unique case (st_cur_r)
      ST_IDLE:    if (accept_in && !is_load) st_nxt = ST_POSE1;
      ST_POSE1:   st_nxt = ST_POSE1_W;
      ST_POSE1_W: if (cs_done) st_nxt = ST_POSE1_M;
      ST_POSE1_M: st_nxt = ST_POSE2;
      ST_POSE2:   st_nxt = ST_POSE2_W;
      ST_POSE2_W: if (cs_done) st_nxt = ST_POSE2_M;
      ST_POSE2_M: st_nxt = ST_AIM_M;
      ST_AIM_M:   st_nxt = ST_AIM1;
      ST_AIM1:    st_nxt = ST_AIM1_W;
      ST_AIM1_W:  if (cs_done) st_nxt = ST_AIM2;
      ST_AIM2:    st_nxt = ST_AIM2_W;
      ST_AIM2_W:  if (cs_done) st_nxt = (lim == '0) ? ST_OUT : ST_RD;
      ST_RD:      st_nxt = ST_DIFF;
      ST_DIFF:    st_nxt = ST_MUL;
      ST_MUL:     st_nxt = skip_now ? ST_CMP : ST_SQRT;
      ST_SQRT:    if (sq_done) st_nxt = ST_CMP;
      ST_CMP: begin
        if (idx_r + 1'b1 < lim) st_nxt = ST_RD;
        else st_nxt = (found_r || cmp_hit) ? ST_ATAN : ST_OUT;
      end
      ST_ATAN:    st_nxt = ST_ATAN_W;
      ST_ATAN_W:  if (cs_done) st_nxt = ST_FIN;
      ST_FIN:     st_nxt = ST_FIN_W;
      ST_FIN_W:   if (cs_done) st_nxt = ST_FIN_M;
      ST_FIN_M:   st_nxt = ST_FIN_S;
      ST_FIN_S:   st_nxt = ST_OUT;
      ST_OUT:     if (out_free) st_nxt = ST_IDLE;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  // outputs to the shared units
  logic [31:0] h1, h2;
  assign h1 = {sh_r, 16'h0};
  assign h2 = {eh_r, 16'h0};

  always_comb begin
    cs_start = 1'b0; cs_mode = CORDIC_ROT; cs_angle = h1;
    cs_vx = 40'(bdx_r); cs_vy = 40'(bdy_r);
    sq_start = 1'b0;
    unique case (st_cur_r)
      ST_POSE1: begin cs_start = 1'b1; cs_angle = h1; end
      ST_POSE2: begin cs_start = 1'b1; cs_angle = h2; end
      ST_AIM1:  begin cs_start = 1'b1; cs_angle = tp1_r[47:16] + h1; end
      ST_AIM2:  begin cs_start = 1'b1; cs_angle = tp2_r[47:16] + h2; end
      ST_ATAN:  begin cs_start = 1'b1; cs_mode = CORDIC_VEC; end
      ST_FIN:   begin cs_start = 1'b1; cs_angle = {brg_r, 16'h0} + h1; end
      ST_MUL:   sq_start = !skip_now;
      default: ;
    endcase
  end

  // search compare
  assign d1 = pa_r - pb_r;
  assign d2 = pc_r - pd_r;
  // squares only matter when both differences fit in 32 bits
  assign sqx = 64'(signed'(dx_r[31:0])) * 64'(signed'(dx_r[31:0]));
  assign sqy = 64'(signed'(dy_r[31:0])) * 64'(signed'(dy_r[31:0]));
  assign sq_rad = sqx + sqy;
  assign cmp_hit = (st_cur_r == ST_CMP) && !skip_r && (d1 > 0) && (d2 < 0)
                   && ({1'b0, sq_root} < {1'b0, best_r});
  assign idx_nxt = idx_r + 1'b1;

  logic signed [34:0] bx_e, by_e;
  assign bx_e = 35'(signed'(bx_rd));
  assign by_e = 35'(signed'(by_rd));

  logic [31:0] brg_sum;
  assign brg_sum = cs_ang - h1 + 32'h8000;

  logic signed [63:0] wx_full, wy_full;
  assign wx_full = 64'(rx1_r) + (pa_r >>> 30);
  assign wy_full = 64'(ry1_r) + (pb_r >>> 30);

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // sequential datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_cur_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      found_r <= 1'b0;
      idx_r <= '0;
    end else begin
      st_cur_r <= st_nxt;
      unique case (st_cur_r)
        ST_IDLE: begin
          if (accept_in && !is_load) begin
            sx_r <= in_tdata[103:72];  sy_r <= in_tdata[135:104];
            sh_r <= in_tdata[151:136]; st_r <= in_tdata[183:152];
            ex_r <= in_tdata[215:184]; ey_r <= in_tdata[247:216];
            eh_r <= in_tdata[263:248]; et_r <= in_tdata[295:264];
          end
        end
        ST_POSE1_W, ST_POSE2_W, ST_FIN_W: if (cs_done) begin
          if (st_cur_r == ST_FIN_W) begin
            pa_r <= 64'(best_r) * 64'(cos32);
            pb_r <= 64'(best_r) * 64'(sin32);
          end else begin
            pa_r <= 64'(off_x_r) * 64'(cos32);
            pb_r <= 64'(off_y_r) * 64'(sin32);
            pc_r <= 64'(off_x_r) * 64'(sin32);
            pd_r <= 64'(off_y_r) * 64'(cos32);
          end
        end
        ST_POSE1_M: begin
          rx1_r <= 34'(sx_r) + 34'((pa_r - pb_r) >>> 30);
          ry1_r <= 34'(sy_r) + 34'((pc_r + pd_r) >>> 30);
        end
        ST_POSE2_M: begin
          rx2_r <= 34'(ex_r) + 34'((pa_r - pb_r) >>> 30);
          ry2_r <= 34'(ey_r) + 34'((pc_r + pd_r) >>> 30);
        end
        ST_AIM_M: begin
          tp1_r <= 64'(st_r) * 64'(sweep_r);
          tp2_r <= 64'(et_r) * 64'(sweep_r);
        end
        ST_AIM1_W: if (cs_done) begin
          c1_r <= 26'(cs_cos >>> 14); s1_r <= 26'(cs_sin >>> 14);
        end
        ST_AIM2_W: if (cs_done) begin
          c2_r <= 26'(cs_cos >>> 14); s2_r <= 26'(cs_sin >>> 14);
          idx_r <= '0; found_r <= 1'b0; best_r <= {1'b0, maxr_r};
        end
        ST_DIFF: begin
          dx_r  <= bx_e - 35'(rx1_r);
          dy_r  <= by_e - 35'(ry1_r);
          ex2_r <= bx_e - 35'(rx2_r);
          ey2_r <= by_e - 35'(ry2_r);
        end
        ST_MUL: begin
          // cross products for the between test
          skip_r <= skip_now;
          pa_r <= 64'(dy_r) * 64'(c1_r);
          pb_r <= 64'(dx_r) * 64'(s1_r);
          pc_r <= 64'(ey2_r) * 64'(c2_r);
          pd_r <= 64'(ex2_r) * 64'(s2_r);
        end
        ST_CMP: begin
          if (cmp_hit) begin
            best_r <= sq_root; bidx_r <= idx_r[IDX_W-1:0]; found_r <= 1'b1;
            bdx_r <= dx_r; bdy_r <= dy_r;
          end
          idx_r <= idx_nxt;
        end
        ST_ATAN_W: if (cs_done) brg_r <= brg_sum[31:16];
        default: ;
      endcase
      if (st_cur_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
        if (found_r) begin
          out_data_r <= {st_r, sat32(wy_full), sat32(wx_full), bidx_r, brg_r,
                         best_r[30:0], 1'b1};
        end else begin
          out_data_r <= {st_r, 120'h0};
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // skip a beacon whose offset from the radar lies outside -(2^31-1)..2^31-1
  logic signed [34:0] lim_hi;
  assign lim_hi = 35'sd2147483647;
  assign skip_now = (dx_r > lim_hi) || (dx_r < -lim_hi) ||
                    (dy_r > lim_hi) || (dy_r < -lim_hi);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("result dropped or changed while stalled");
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    (st_cur_r != ST_IDLE) |-> !in_tready) else $error("item taken while busy");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_cur_r == ST_RD) |-> idx_r < lim) else $error("search index out of range");

endmodule

### tb/nearest_beacon_in_radar_sweep_check.sv
// Checker for the radar sweep beacon search: predicts each observe result and compares it.
module nearest_beacon_in_radar_sweep_check
  import nbrs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [295:0] in_tdata,
  input  logic         in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [151:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  output int           errors,
  output int           pending,
  output int           found_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit FN_OBSERVE = 1'b1;
  localparam longint GAIN = 64'sd652032874;

  // packed from the top bit down: found lands in bit 0
  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] wy;
    logic [31:0] wx;
    logic [7:0]  index;
    logic [15:0] bearing;
    logic [30:0] range;
    logic        found;
  } sighting_t;

  longint unsigned arctan[32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  longint      off_x, off_y;
  logic [31:0] sweep;
  logic [30:0] max_rng;
  logic [8:0]  n_beacons;
  longint      tab_x[BEACONS];
  longint      tab_y[BEACONS];
  sighting_t   sightings[$];

  assign pending = sightings.size();

  function automatic void rotate(input logic [31:0] a, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit     flip;
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (flip) a = a + 32'h8000_0000;
    x = GAIN;
    y = 0;
    z = longint'(signed'(a));
    for (int i = 0; i < ANGLE_BITS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(arctan[i]);
      end else begin
        x += dx; y -= dy; z += longint'(arctan[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] bearing_of(input longint y, input longint x);
    logic [31:0] z;
    longint      nx;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    for (int i = 0; i < ANGLE_BITS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + arctan[i][31:0];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - arctan[i][31:0];
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic longint unsigned root(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b; res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void mount(input longint px, input longint py, input logic [31:0] hd,
                                output longint rx, output longint ry);
    longint c, s;
    rotate(hd, c, s);
    rx = px + ((off_x * c - off_y * s) >>> 30);
    ry = py + ((off_x * s + off_y * c) >>> 30);
  endfunction

  function automatic logic [31:0] aim(input logic [31:0] t, input logic [31:0] h);
    logic [63:0] p;
    p = {32'd0, t} * {32'd0, sweep};
    return p[47:16] + h;
  endfunction

  function automatic sighting_t search(input logic [295:0] d);
    sighting_t       r;
    logic [31:0]     h1, h2, a1, a2, ang, brg;
    longint          rx1, ry1, rx2, ry2, c1, s1, c2, s2, dx, dy, d1, d2, c, s;
    longint unsigned best, rr;
    int              lim, bidx;
    bit              hit;
    h1 = {d[151:136], 16'd0};
    h2 = {d[263:248], 16'd0};
    mount(longint'(signed'(d[103:72])), longint'(signed'(d[135:104])), h1, rx1, ry1);
    mount(longint'(signed'(d[215:184])), longint'(signed'(d[247:216])), h2, rx2, ry2);
    a1 = aim(d[183:152], h1);
    a2 = aim(d[295:264], h2);
    rotate(a1, c1, s1);
    rotate(a2, c2, s2);
    c1 = c1 >>> 14; s1 = s1 >>> 14;
    c2 = c2 >>> 14; s2 = s2 >>> 14;
    best = 64'(max_rng);
    bidx = 0;
    hit = 0;
    lim = (n_beacons > BEACONS) ? BEACONS : int'(n_beacons);
    for (int i = 0; i < lim; i++) begin
      dx = tab_x[i] - rx1;
      dy = tab_y[i] - ry1;
      if (dx >= 64'sd2147483648 || dx <= -64'sd2147483648) continue;
      if (dy >= 64'sd2147483648 || dy <= -64'sd2147483648) continue;
      rr = root(longint'(dx * dx) + longint'(dy * dy));
      d1 = dy * c1 - dx * s1;
      d2 = (tab_y[i] - ry2) * c2 - (tab_x[i] - rx2) * s2;
      if (d1 > 0 && d2 < 0 && rr < best) begin
        best = rr; bidx = i; hit = 1;
      end
    end
    r = '0;
    r.stamp = d[183:152];
    if (!hit) return r;
    ang = bearing_of(tab_y[bidx] - ry1, tab_x[bidx] - rx1);
    brg = (ang - h1 + 32'h8000) >> 16;
    rotate({brg[15:0], 16'd0} + h1, c, s);
    r.found = 1'b1;
    r.range = best[30:0];
    r.bearing = brg[15:0];
    r.index = bidx[7:0];
    r.wx = 32'(clamp32(rx1 + ((longint'(best) * c) >>> 30)));
    r.wy = 32'(clamp32(ry1 + ((longint'(best) * s) >>> 30)));
    return r;
  endfunction

  always @(posedge clk) begin
    sighting_t want, got;
    if (!rst_n) begin
      off_x <= 0;
      off_y <= 0;
      sweep <= '0;
      max_rng <= 31'h7FFF_FFFF;
      n_beacons <= '0;
      sightings.delete();
      errors <= 0;
      found_cnt <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OFF_X:  off_x <= longint'(signed'(cfg_wdata));
          REG_OFF_Y:  off_y <= longint'(signed'(cfg_wdata));
          REG_SWEEP:  sweep <= cfg_wdata;
          REG_MAXRNG: max_rng <= cfg_wdata[30:0];
          REG_BCOUNT: n_beacons <= cfg_wdata[8:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == FN_OBSERVE) begin
          sightings.push_back(search(in_tdata));
        end else begin
          tab_x[in_tdata[7:0]] = longint'(signed'(in_tdata[39:8]));
          tab_y[in_tdata[7:0]] = longint'(signed'(in_tdata[71:40]));
        end
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (sightings.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result item %h", out_tdata);
        end else begin
          want = sightings.pop_front();
          if (got.found) found_cnt <= found_cnt + 1;
          if (got != want) begin
            errors <= errors + 1;
            if (errors < 10) begin
              $display("mismatch: found %0d/%0d range %h/%h bearing %h/%h index %0d/%0d",
                       want.found, got.found, want.range, got.range,
                       want.bearing, got.bearing, want.index, got.index);
              $display("          world_x %h/%h world_y %h/%h stamp %h/%h (want/got)",
                       want.wx, got.wx, want.wy, got.wy, want.stamp, got.stamp);
            end
          end
        end
      end
    end
  end

endmodule

### tb/nearest_beacon_in_radar_sweep_test.sv
// Stimulus and verdict for the radar sweep beacon search.
module nearest_beacon_in_radar_sweep_test;
  import nbrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit FN_LOAD    = 1'b0;
  localparam bit FN_OBSERVE = 1'b1;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [295:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_wdata = '0;

  int errors, pending, found_cnt;
  int n_loads, n_observes;
  bit quiet_tx, quiet_rx, hold_req, held;

  nearest_beacon_in_radar_sweep uut (.*);

  nearest_beacon_in_radar_sweep_check chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_index, .cfg_wdata,
    .errors, .pending, .found_cnt
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #40ms;
    $display("nearest_beacon_in_radar_sweep_test: errors");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mostly positions within a few hundred meters, sometimes anywhere.
  function automatic logic [31:0] coord();
    if ($urandom_range(0, 99) < 88) return $urandom_range(0, 26214400) - 32'd13107200;
    return $urandom;
  endfunction

  always begin
    @(posedge clk);
    if (hold_req && !held) begin
      held = 1;
      out_tready <= 1'b0;
      repeat (3000) @(posedge clk);
    end else if (quiet_rx || $urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  end

  task automatic put_item(input bit fn, input logic [295:0] d);
    int g;
    g = quiet_tx ? 0 : gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    if (fn == FN_OBSERVE) n_observes++; else n_loads++;
  endtask

  task automatic load(input logic [7:0] slot, input logic [31:0] x, input logic [31:0] y);
    put_item(FN_LOAD, {224'd0, y, x, slot});
  endtask

  task automatic observe(input logic [31:0] sx, input logic [31:0] sy, input logic [15:0] sh,
                         input logic [31:0] st, input logic [31:0] ex, input logic [31:0] ey,
                         input logic [15:0] eh, input logic [31:0] et);
    put_item(FN_OBSERVE, {et, eh, ey, ex, st, sh, sy, sx, 72'd0});
  endtask

  task automatic observe_rand();
    logic [31:0] sx, sy;
    sx = coord();
    sy = coord();
    // end pose usually a short drive from the start pose
    observe(sx, sy, 16'($urandom), $urandom, sx + $urandom_range(0, 655360) - 32'd327680,
            sy + $urandom_range(0, 655360) - 32'd327680, 16'($urandom), $urandom);
  endtask

  // Drain, let the block settle, then write every register.
  task automatic set_regs(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] sw,
                          input logic [31:0] mr, input logic [31:0] cnt);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_OFF_X;  cfg_wdata <= ox; @(posedge clk);
    cfg_index <= REG_OFF_Y;  cfg_wdata <= oy; @(posedge clk);
    cfg_index <= REG_SWEEP;  cfg_wdata <= sw; @(posedge clk);
    cfg_index <= REG_MAXRNG; cfg_wdata <= mr; @(posedge clk);
    cfg_index <= REG_BCOUNT; cfg_wdata <= cnt; @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int wait_cnt;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // fill the whole table first: extremes, origin, a tied pair, then random
    quiet_tx = 1;
    load(8'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    load(8'd1, 32'h8000_0000, 32'h8000_0000);
    load(8'd2, 32'd0, 32'd0);
    load(8'd3, 32'h0005_0000, 32'h0000_0000);
    load(8'd4, 32'h0005_0000, 32'h0000_0000);
    quiet_tx = 0;
    for (int i = 5; i < BEACONS; i++) load(i[7:0], coord(), coord());

    // reset settings: nothing searched
    observe(0, 0, 0, 0, 0, 0, 16'h4000, 0);

    set_regs(0, 0, 0, 32'h7FFF_FFFF, 256);
    observe(0, 0, 16'hC000, 0, 0, 0, 16'h4000, 0);
    observe(0, 0, 16'h8000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 0);
    observe(32'h7FFF_0000, 32'h7FFF_0000, 16'hC000, 1, 32'h7FFF_0000, 32'h7FFF_0000,
            16'h3FFF, 1);
    observe(32'h8000_0000, 32'h8000_0000, 16'h0000, 0, 32'h8000_0000, 32'h8000_0000,
            16'h8000, 0);
    observe(32'h0005_0000, 0, 16'h0000, 0, 32'h0005_0000, 0, 16'h7000, 0);

    set_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 511);
    observe(0, 0, 16'hC000, 0, 0, 0, 16'h4000, 0);
    set_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF, 511);
    observe(0, 0, 16'h8001, 32'h0002_0000, 32'h0001_0000, 0, 16'h7FFF, 32'hFFFF_0000);
    observe_rand();

    for (int ph = 0; ph < 10; ph++) begin
      quiet_tx = (ph % 4 == 3);
      quiet_rx = (ph % 3 == 2);
      set_regs(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 655360) - 327680,
               ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 655360) - 327680,
               $urandom,
               ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32'h0100_0000)
                                          : 32'h7FFF_FFFF,
               (ph == 9) ? 256 : $urandom_range(1, 12));
      if (ph == 4) hold_req = 1;
      for (int k = 0; k < ((ph == 9) ? 6 : 100); k++) begin
        if ($urandom_range(0, 99) < 70) observe_rand();
        else load(8'($urandom), coord(), coord());
      end
    end

    in_tvalid <= 1'b0;
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (20) @(posedge clk);
    $display("covered %0d loads and %0d observes, %0d of them found a beacon",
             n_loads, n_observes, found_cnt);
    $display("settings included offset, sweep, range and count extremes and a long output stall");
    if (errors == 0 && pending == 0) begin
      $display("nearest_beacon_in_radar_sweep_test: clean");
    end else begin
      $display("nearest_beacon_in_radar_sweep_test: errors");
    end
    $finish;
  end

endmodule
